// ===== hdl/ads_pkg.sv =====
// Shared types, constants and constant functions for the angular distance color shader.
// No dependencies; the top level, ads_cos and ads_search import this package.
package ads_pkg;

    // Fixed formats of the item fields
    localparam int TRIG_FRAC_BITS = 14;
    localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
    localparam int ANGLE_BITS     = 16;
    // left shift that brings a product of two trig values to Q30
    localparam int Q30_LSHIFT     = 30 - 2 * TRIG_FRAC_BITS;

    // Datapath widths
    localparam int QW      = 34;   // Q30 working values, room for +/- 2^32
    localparam int SUM_W   = 32;   // clamped cosine sum, +/- 2^30
    localparam int DEG_W   = 8;
    localparam int DEG_MAX = 180;
    localparam int HORNER_STEPS = 5;

    localparam int MAP_DEPTH_DEF = 256;

    // Configuration register indexes
    localparam logic [1:0] CFG_CENTER_SIN = 2'd0;
    localparam logic [1:0] CFG_CENTER_COS = 2'd1;
    localparam logic [1:0] CFG_CENTER_AZ  = 2'd2;

    localparam logic signed [15:0] CENTER_SIN_RST = 16'sd0;
    localparam logic signed [15:0] CENTER_COS_RST = 16'sd16384;
    localparam logic [15:0]        CENTER_AZ_RST  = 16'd0;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_SHADE = 1'b1;

    // Polynomial coefficients, Q30
    localparam longint Q30_ONE_L = 64'sd1073741824;
    localparam longint K_S1  = 64'sd1686629713;
    localparam longint K_S3  = 64'sd693598669;
    localparam longint K_S5  = 64'sd85569306;
    localparam longint K_S7  = 64'sd5026994;
    localparam longint K_S9  = 64'sd172271;
    localparam longint K_C2  = 64'sd1324675879;
    localparam longint K_C4  = 64'sd272375558;
    localparam longint K_C6  = 64'sd22401991;
    localparam longint K_C8  = 64'sd987048;
    localparam longint K_C10 = 64'sd27060;

    localparam logic signed [QW-1:0] Q30_ONE = QW'(Q30_ONE_L);
    localparam logic signed [2*QW-1:0] Q30_DIV = (2*QW)'(Q30_ONE_L);

    // Horner seeds and addends, in evaluation order
    typedef logic signed [QW-1:0] coef_arr_t [HORNER_STEPS];
    localparam coef_arr_t SIN_COEF = '{QW'(K_S9), QW'(-K_S7), QW'(K_S5), QW'(-K_S3), QW'(K_S1)};
    localparam coef_arr_t COS_COEF = '{QW'(-K_C10), QW'(K_C8), QW'(-K_C6), QW'(K_C4),
                                       QW'(-K_C2)};

    // Beats
    typedef struct packed {
        logic                      mode;
        logic signed [TRIG_W-1:0]  point_ele_sin;
        logic signed [TRIG_W-1:0]  point_ele_cos;
        logic [ANGLE_BITS-1:0]     point_azimuth;
        logic [7:0]                map_index;
        logic [7:0]                map_red;
        logic [7:0]                map_green;
        logic [7:0]                map_blue;
    } item_t;

    typedef struct packed {
        logic [DEG_W-1:0] degree_distance;
        logic [7:0]       out_red;
        logic [7:0]       out_green;
        logic [7:0]       out_blue;
    } result_t;

    // Q30 product, truncated toward zero
    function automatic logic signed [QW-1:0] qmul_q30(input logic signed [QW-1:0] a,
                                                      input logic signed [QW-1:0] b);
        logic signed [2*QW-1:0] prod;
        logic signed [2*QW-1:0] quo;
        prod = a * b;
        quo  = prod / Q30_DIV;
        return quo[QW-1:0];
    endfunction

    // Elaboration-time versions of the cosine routine
    function automatic longint qmul_c(input longint a, input longint b);
        return (a * b) / Q30_ONE_L;
    endfunction

    function automatic longint quarter_sin_c(input longint x);
        longint t;
        longint p;
        t = qmul_c(x, x);
        p = K_S9;
        p = qmul_c(t, p) - K_S7;
        p = qmul_c(t, p) + K_S5;
        p = qmul_c(t, p) - K_S3;
        p = qmul_c(t, p) + K_S1;
        return qmul_c(x, p);
    endfunction

    function automatic longint quarter_cos_c(input longint x);
        longint t;
        longint p;
        t = qmul_c(x, x);
        p = -K_C10;
        p = qmul_c(t, p) + K_C8;
        p = qmul_c(t, p) - K_C6;
        p = qmul_c(t, p) + K_C4;
        p = qmul_c(t, p) - K_C2;
        return qmul_c(t, p) + Q30_ONE_L;
    endfunction

    function automatic longint turn_cos_c(input longint a);
        longint x;
        longint q;
        longint r;
        x = a % 64'sd1073741824;
        q = (a / 64'sd1073741824) % 64'sd4;
        case (q)
            64'sd0:  r = quarter_cos_c(x);
            64'sd1:  r = -quarter_sin_c(x);
            64'sd2:  r = -quarter_cos_c(x);
            default: r = quarter_sin_c(x);
        endcase
        return r;
    endfunction

    // cos((k + 0.5) degrees) for k = 0..179; unused tail is zero
    typedef logic signed [SUM_W-1:0] thr_arr_t [256];

    function automatic thr_arr_t build_thr();
        thr_arr_t t;
        longint ang;
        for (int k = 0; k < 256; k++)
        begin
            if (k < DEG_MAX)
            begin
                ang  = (longint'(2 * k + 1) * 64'sd4294967296 + 64'sd360) / 64'sd720;
                t[k] = SUM_W'(turn_cos_c(ang));
            end
            else
            begin
                t[k] = '0;
            end
        end
        return t;
    endfunction

    localparam thr_arr_t DEG_THR = build_thr();

    // Brightness attenuation curve
    localparam logic [7:0] ATTEN_ROM [256] = '{
        8'd0,8'd0,8'd0,8'd1,8'd1,8'd2,8'd2,8'd3,8'd3,8'd4,8'd4,8'd5,8'd5,8'd6,8'd6,8'd7,
        8'd7,8'd8,8'd8,8'd9,8'd9,8'd10,8'd10,8'd11,8'd11,8'd12,8'd12,8'd13,8'd13,8'd14,
        8'd14,8'd15,
        8'd15,8'd16,8'd17,8'd17,8'd18,8'd18,8'd19,8'd19,8'd20,8'd20,8'd21,8'd21,8'd22,
        8'd22,8'd23,8'd23,8'd24,8'd24,8'd25,8'd25,8'd26,8'd26,8'd27,8'd28,8'd28,8'd29,
        8'd29,8'd30,8'd30,8'd31,
        8'd31,8'd32,8'd32,8'd33,8'd33,8'd34,8'd35,8'd35,8'd36,8'd36,8'd37,8'd37,8'd38,
        8'd38,8'd39,8'd40,8'd40,8'd41,8'd41,8'd42,8'd42,8'd43,8'd44,8'd44,8'd45,8'd45,
        8'd46,8'd46,8'd47,8'd48,
        8'd48,8'd49,8'd49,8'd50,8'd50,8'd51,8'd52,8'd52,8'd53,8'd53,8'd54,8'd55,8'd55,
        8'd56,8'd56,8'd57,8'd58,8'd58,8'd59,8'd59,8'd60,8'd61,8'd61,8'd62,8'd63,8'd63,
        8'd64,8'd64,8'd65,8'd66,
        8'd66,8'd67,8'd68,8'd68,8'd69,8'd69,8'd70,8'd71,8'd71,8'd72,8'd73,8'd73,8'd74,
        8'd75,8'd75,8'd76,8'd77,8'd77,8'd78,8'd79,8'd79,8'd80,8'd81,8'd81,8'd82,8'd83,
        8'd83,8'd84,8'd85,8'd86,
        8'd86,8'd87,8'd88,8'd88,8'd89,8'd90,8'd91,8'd91,8'd92,8'd93,8'd93,8'd94,8'd95,
        8'd96,8'd96,8'd97,8'd98,8'd99,8'd100,8'd100,8'd101,8'd102,8'd103,8'd103,8'd104,
        8'd105,8'd106,8'd107,8'd107,8'd108,
        8'd109,8'd110,8'd111,8'd112,8'd112,8'd113,8'd114,8'd115,8'd116,8'd117,8'd118,
        8'd119,8'd119,8'd120,8'd121,8'd122,8'd123,8'd124,8'd125,8'd126,8'd127,8'd128,
        8'd129,8'd130,8'd131,8'd132,8'd133,8'd134,8'd135,8'd136,
        8'd137,8'd138,8'd140,8'd141,8'd142,8'd143,8'd144,8'd145,8'd147,8'd148,8'd149,
        8'd150,8'd152,8'd153,8'd154,8'd156,8'd157,8'd159,8'd160,8'd162,8'd163,8'd165,
        8'd167,8'd168,8'd170,8'd172,8'd174,8'd176,8'd178,8'd180,
        8'd182,8'd185,8'd187,8'd190,8'd193,8'd196,8'd200,8'd204,8'd208,8'd213,8'd219,
        8'd227,8'd237,8'd255
    };

endpackage

// ===== hdl/angular_distance_color_shader_top.sv =====
// Top level of the angular distance color shader: pipeline control, config, map RAM.
// Depends on ads_pkg, ads_cos, ads_search and ads_ram.
//
// One item is taken per cycle while item_ready is high. A shade result is presented
// through an 18-stage elastic pipeline: products, six cosine stages, the
// cosine sum, eight degree search stages, the color map RAM read and the attenuation
// output register. Each stage holds its beat while downstream is full, so bubbles are
// squeezed out and nothing is lost while a result waits; input stalls only once every
// stage holds a beat. Load items travel the same pipeline and write the map at the RAM
// stage, so shades see exactly the loads that came before them; they give no result.
// The map is undefined until loaded.
module angular_distance_color_shader_top #(
    parameter int MAP_DEPTH = ads_pkg::MAP_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data,
    input  logic            item_valid,
    output logic            item_ready,
    input  ads_pkg::item_t  item,
    output logic            result_valid,
    input  logic            result_ready,
    output ads_pkg::result_t result
);
    import ads_pkg::*;

    localparam int ADDR_W   = $clog2(MAP_DEPTH);
    localparam int NS       = 18;
    localparam int ST_PROD  = 0;
    localparam int ST_SUM   = 7;
    localparam int ST_SRCH  = 8;
    localparam int ST_RAM   = 16;
    localparam int ST_OUT   = 17;

    typedef struct packed {
        logic                 mode;
        logic [7:0]           map_index;
        logic [23:0]          rgb;
        logic signed [QW-1:0] ss;
        logic signed [QW-1:0] cc;
    } side_t;

    // config registers
    logic signed [TRIG_W-1:0] center_sin_reg;
    logic signed [TRIG_W-1:0] center_cos_reg;
    logic [ANGLE_BITS-1:0]    center_az_reg;

    // pipeline control
    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS:0]   en;

    // stage data
    side_t                side_reg [ST_RAM];
    side_t                side_next;
    logic signed [QW-1:0] x0_reg;
    logic [1:0]           quad0_reg;
    logic signed [QW-1:0] cos_val;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic [DEG_W-1:0]     deg_val;
    logic [DEG_W-1:0]     deg16_reg;
    result_t              result_reg;

    // stage 0 helpers
    logic signed [2*TRIG_W-1:0] ss_prod;
    logic signed [2*TRIG_W-1:0] cc_prod;
    logic [ANGLE_BITS-1:0]      daz;
    logic [31:0]                turn;

    // RAM ports
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [23:0]       ram_rdata;
    logic [ADDR_W+7:0] idx_wide;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_sin_reg <= CENTER_SIN_RST;
            center_cos_reg <= CENTER_COS_RST;
            center_az_reg  <= CENTER_AZ_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CENTER_SIN: center_sin_reg <= TRIG_W'(cfg_data);
                CFG_CENTER_COS: center_cos_reg <= TRIG_W'(cfg_data);
                CFG_CENTER_AZ:  center_az_reg  <= ANGLE_BITS'(cfg_data);
                default:        ;
            endcase
        end
    end

    // stage enables: a stage loads when empty or when its beat moves on
    always_comb
    begin
        en[NS] = result_ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            en[i] = ~v_reg[i] | en[i+1];
        end
    end

    // valid bits; load beats drop out at the RAM stage
    always_comb
    begin
        v_next[0] = item_valid;
        for (int i = 1; i < NS; i++)
        begin
            v_next[i] = v_reg[i-1];
        end
        v_next[ST_RAM] = v_reg[ST_RAM-1] & (side_reg[ST_RAM-1].mode == MODE_SHADE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_next[i];
                end
            end
        end
    end

    assign item_ready = en[0];

    // stage 0: elevation products and azimuth difference
    always_comb
    begin
        ss_prod = item.point_ele_sin * center_sin_reg;
        cc_prod = item.point_ele_cos * center_cos_reg;
        daz     = item.point_azimuth - center_az_reg;
        turn    = {daz, {(32 - ANGLE_BITS){1'b0}}};
        side_next.mode      = item.mode;
        side_next.map_index = item.map_index;
        side_next.rgb       = {item.map_red, item.map_green, item.map_blue};
        side_next.ss        = QW'(ss_prod) <<< Q30_LSHIFT;
        side_next.cc        = QW'(cc_prod) <<< Q30_LSHIFT;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_PROD])
        begin
            side_reg[0] <= side_next;
            x0_reg      <= QW'({2'b00, turn[29:0]});
            quad0_reg   <= turn[31:30];
        end
    end

    // sideband shift line alongside the datapath
    for (genvar g = 1; g < ST_RAM; g++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en[g])
            begin
                side_reg[g] <= side_reg[g-1];
            end
        end
    end

    // stages 1..6: cosine of the azimuth difference
    ads_cos u_cos (
        .clk     (clk),
        .en      (en[ST_SUM-1:ST_PROD+1]),
        .x_in    (x0_reg),
        .quad_in (quad0_reg),
        .cos_out (cos_val)
    );

    // stage 7: cosine sum, clamped to [-1, 1]
    always_comb
    begin
        logic signed [2*QW-1:0] prod;
        logic signed [2*QW-1:0] quo;
        logic signed [QW+1:0]   total;
        prod  = side_reg[ST_SUM-1].cc * cos_val;
        quo   = prod / Q30_DIV;
        total = (QW+2)'(quo) + (QW+2)'(side_reg[ST_SUM-1].ss);
        if (total > (QW+2)'(Q30_ONE))
        begin
            sum_next = SUM_W'(Q30_ONE);
        end
        else if (total < -(QW+2)'(Q30_ONE))
        begin
            sum_next = -SUM_W'(Q30_ONE);
        end
        else
        begin
            sum_next = SUM_W'(total);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            sum_reg <= sum_next;
        end
    end

    // stages 8..15: degree search
    ads_search u_search (
        .clk     (clk),
        .en      (en[ST_RAM-1:ST_SRCH]),
        .sum_in  (sum_reg),
        .deg_out (deg_val)
    );

    // stage 16: map write for loads, map read for shades
    always_comb
    begin
        idx_wide  = (ADDR_W+8)'(side_reg[ST_RAM-1].map_index);
        ram_we    = en[ST_RAM] & v_reg[ST_RAM-1] & (side_reg[ST_RAM-1].mode == MODE_LOAD)
                    & (idx_wide < (ADDR_W+8)'(MAP_DEPTH));
        ram_waddr = idx_wide[ADDR_W-1:0];
        ram_re    = en[ST_RAM] & v_reg[ST_RAM-1] & (side_reg[ST_RAM-1].mode == MODE_SHADE);
        ram_raddr = ADDR_W'(deg_val);
    end

    ads_ram #(
        .WIDTH (24),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (side_reg[ST_RAM-1].rgb),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (en[ST_RAM])
        begin
            deg16_reg <= deg_val;
        end
    end

    // stage 17: attenuation and output register
    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            result_reg.degree_distance <= deg16_reg;
            result_reg.out_red         <= ATTEN_ROM[ram_rdata[23:16]];
            result_reg.out_green       <= ATTEN_ROM[ram_rdata[15:8]];
            result_reg.out_blue        <= ATTEN_ROM[ram_rdata[7:0]];
        end
    end

    assign result_valid = v_reg[ST_OUT];
    assign result       = result_reg;

endmodule

// ===== hdl/ads_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ads_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/ads_cos.sv =====
// Six-stage cosine of a turn fraction: square, four Horner steps, final term and sign.
// Depends on ads_pkg; stage enables come from the top level's pipeline control.
module ads_cos (
    input  logic                          clk,
    input  logic [5:0]                    en,
    input  logic signed [ads_pkg::QW-1:0] x_in,
    input  logic [1:0]                    quad_in,
    output logic signed [ads_pkg::QW-1:0] cos_out
);
    import ads_pkg::*;

    logic signed [QW-1:0] x_reg [5];
    logic signed [QW-1:0] t_reg [5];
    logic [1:0]           quad_reg [5];
    logic signed [QW-1:0] p_reg [5];
    logic signed [QW-1:0] cos_reg;

    logic signed [QW-1:0] p_next [5];
    logic signed [QW-1:0] fin_op;
    logic signed [QW-1:0] fin_val;
    logic signed [QW-1:0] cos_next;

    // Horner steps: quadrants 1 and 3 use the sine polynomial
    always_comb
    begin
        p_next[0] = '0;
        for (int s = 1; s < 5; s++)
        begin
            if (quad_reg[s-1][0])
            begin
                p_next[s] = qmul_q30(t_reg[s-1], (s == 1) ? SIN_COEF[0] : p_reg[s-1])
                            + SIN_COEF[s];
            end
            else
            begin
                p_next[s] = qmul_q30(t_reg[s-1], (s == 1) ? COS_COEF[0] : p_reg[s-1])
                            + COS_COEF[s];
            end
        end
    end

    // final term, negated in quadrants 1 and 2
    always_comb
    begin
        fin_op  = quad_reg[4][0] ? x_reg[4] : t_reg[4];
        fin_val = qmul_q30(fin_op, p_reg[4]) + (quad_reg[4][0] ? QW'(0) : Q30_ONE);
        cos_next = (quad_reg[4][0] ^ quad_reg[4][1]) ? -fin_val : fin_val;
    end

    // stage 0: square of the quarter-turn fraction
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            t_reg[0]    <= qmul_q30(x_in, x_in);
            x_reg[0]    <= x_in;
            quad_reg[0] <= quad_in;
            p_reg[0]    <= '0;
        end
    end

    // stages 1..4: Horner steps
    for (genvar g = 1; g < 5; g++)
    begin : g_horner
        always_ff @(posedge clk)
        begin
            if (en[g])
            begin
                t_reg[g]    <= t_reg[g-1];
                x_reg[g]    <= x_reg[g-1];
                quad_reg[g] <= quad_reg[g-1];
                p_reg[g]    <= p_next[g];
            end
        end
    end

    // stage 5: result
    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            cos_reg <= cos_next;
        end
    end

    assign cos_out = cos_reg;

endmodule

// ===== hdl/ads_search.sv =====
// Eight-stage binary search of the rounded degree against the constant threshold table.
// Depends on ads_pkg; stage enables come from the top level's pipeline control.
module ads_search (
    input  logic                             clk,
    input  logic [ads_pkg::DEG_W-1:0]        en,
    input  logic signed [ads_pkg::SUM_W-1:0] sum_in,
    output logic [ads_pkg::DEG_W-1:0]        deg_out
);
    import ads_pkg::*;

    logic signed [SUM_W-1:0] sum_reg [DEG_W];
    logic [DEG_W-1:0]        deg_reg [DEG_W];
    logic [DEG_W-1:0]        deg_next [DEG_W];

    // one result bit per stage, most significant first
    always_comb
    begin
        logic [DEG_W-1:0]        prev;
        logic signed [SUM_W-1:0] sv;
        logic [DEG_W-1:0]        cand;
        logic [DEG_W-1:0]        tidx;
        for (int s = 0; s < DEG_W; s++)
        begin
            prev = (s == 0) ? '0 : deg_reg[s-1];
            sv   = (s == 0) ? sum_in : sum_reg[s-1];
            cand = prev | (DEG_W'(1) << (DEG_W - 1 - s));
            tidx = cand - DEG_W'(1);
            if ((cand <= DEG_W'(DEG_MAX)) && (DEG_THR[tidx] >= sv))
            begin
                deg_next[s] = cand;
            end
            else
            begin
                deg_next[s] = prev;
            end
        end
    end

    for (genvar g = 0; g < DEG_W; g++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en[g])
            begin
                sum_reg[g] <= (g == 0) ? sum_in : sum_reg[(g == 0) ? 0 : g-1];
                deg_reg[g] <= deg_next[g];
            end
        end
    end

    assign deg_out = deg_reg[DEG_W-1];

endmodule
